// ----- hw/rtl/ilsu_pkg.sv -----
// Package for the integer load/store unit: beat structs, command codes,
// controller/datapath interface structs. No dependencies.
`timescale 1ns / 1ps
package ilsu_pkg;

	localparam int unsigned MEM_BYTES_DEF = 65536;
	localparam int unsigned NUM_REGS = 32;

	localparam logic [2:0] CMD_LOAD = 3'd0;
	localparam logic [2:0] CMD_STORE = 3'd1;
	localparam logic [2:0] CMD_LMW = 3'd2;
	localparam logic [2:0] CMD_STMW = 3'd3;
	localparam logic [2:0] CMD_PRESET = 3'd4;

	localparam logic [1:0] SZ_BYTE = 2'd0;
	localparam logic [1:0] SZ_HALF = 2'd1;
	localparam logic [1:0] SZ_WORD = 2'd2;

	typedef struct packed {
		logic [2:0] command;
		logic [1:0] access_size;
		logic sign_extend;
		logic update;
		logic indexed;
		logic byte_reverse;
		logic [4:0] target_reg;
		logic [4:0] base_reg;
		logic [4:0] index_reg;
		logic signed [15:0] displacement;
		logic [31:0] preset_value;
	} in_beat_t;

	typedef struct packed {
		logic [4:0] reg_index;
		logic [31:0] data;
		logic [31:0] address;
		logic is_store;
		logic last;
	} out_beat_t;

	// controller -> datapath
	typedef struct packed {
		logic latch_item;   // capture input beat
		logic rd_base;      // read base register
		logic rd_index;     // read index register
		logic calc_ea;      // form effective address
		logic rd_src;       // read source/target register
		logic mem_rd;       // read memory byte k
		logic mem_wr;       // write memory byte k
		logic [1:0] byte_k;
		logic fin_elem;     // finish element: write reg, build result
		logic next_elem;    // advance multiple register/address
		logic wr_update;    // write ea to base
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [2:0] command;
		logic [2:0] nbytes_m1;
		logic is_multi;
		logic do_update;
		logic elem_last;
	} ctl_stat_t;

endpackage

// ----- hw/rtl/ilsu_datapath.sv -----
// Datapath: register file (flops, reset zero), byte memory, address and
// data formatting. Depends on ilsu_pkg.
`timescale 1ns / 1ps
module ilsu_datapath #(
	parameter int unsigned MEM_BYTES = ilsu_pkg::MEM_BYTES_DEF
) (
	input logic clk,
	input logic arst_n,
	input ilsu_pkg::in_beat_t in_beat,
	input ilsu_pkg::ctl_cmd_t cmd,
	output ilsu_pkg::ctl_stat_t stat,
	output ilsu_pkg::out_beat_t res
);
	localparam int unsigned AW = $clog2(MEM_BYTES);

	ilsu_pkg::in_beat_t it_q;
	logic [31:0] rf_q [ilsu_pkg::NUM_REGS];
	logic [7:0] mem [MEM_BYTES];
	logic [31:0] base_q, off_q, ea_q, acc_q, rd_q;
	logic [4:0] cur_q;
	logic [7:0] rdata_q;
	logic [AW-1:0] maddr;
	logic [7:0] wbyte;
	logic [2:0] nb_m1;
	logic brev;
	logic [31:0] ldv, stv, v;

	always_comb begin
		case (it_q.access_size)
			ilsu_pkg::SZ_BYTE: nb_m1 = 3'd0;
			ilsu_pkg::SZ_HALF: nb_m1 = 3'd1;
			default: nb_m1 = 3'd3;
		endcase
	end

	assign stat.command = it_q.command;
	assign stat.is_multi = (it_q.command == ilsu_pkg::CMD_LMW) ||
		(it_q.command == ilsu_pkg::CMD_STMW);
	assign stat.nbytes_m1 = stat.is_multi ? 3'd3 : nb_m1;
	assign stat.do_update = it_q.update && (it_q.command == ilsu_pkg::CMD_LOAD ||
		it_q.command == ilsu_pkg::CMD_STORE);
	assign stat.elem_last = (cur_q == 5'd31);

	assign brev = it_q.byte_reverse && it_q.indexed && nb_m1 != 3'd0 && !stat.is_multi;
	assign maddr = AW'(ea_q + 32'(cmd.byte_k));

	always_comb begin
		case (stat.nbytes_m1)
			3'd0: wbyte = stv[7:0];
			3'd1: wbyte = cmd.byte_k[0] ? stv[7:0] : stv[15:8];
			default: begin
				case (cmd.byte_k)
					2'd0: wbyte = stv[31:24];
					2'd1: wbyte = stv[23:16];
					2'd2: wbyte = stv[15:8];
					default: wbyte = stv[7:0];
				endcase
			end
		endcase
	end

	always_comb begin
		ldv = acc_q;
		if (brev) begin
			ldv = (nb_m1 == 3'd1) ? {16'd0, acc_q[7:0], acc_q[15:8]} :
				{acc_q[7:0], acc_q[15:8], acc_q[23:16], acc_q[31:24]};
		end else if (stat.nbytes_m1 == 3'd1 && it_q.sign_extend && acc_q[15]) begin
			ldv = acc_q | 32'hFFFF_0000;
		end
	end

	always_comb begin
		case (stat.nbytes_m1)
			3'd0: stv = {24'd0, rd_q[7:0]};
			3'd1: stv = {16'd0, rd_q[15:0]};
			default: stv = rd_q;
		endcase
		if (brev) begin
			stv = (nb_m1 == 3'd1) ? {16'd0, rd_q[7:0], rd_q[15:8]} :
				{rd_q[7:0], rd_q[15:8], rd_q[23:16], rd_q[31:24]};
		end
	end

	assign v = (it_q.command == ilsu_pkg::CMD_LOAD || it_q.command == ilsu_pkg::CMD_LMW) ?
		ldv : stv;

	always_ff @(posedge clk) begin
		if (cmd.mem_wr) begin
			mem[maddr] <= wbyte;
		end
		rdata_q <= mem[maddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_item) begin
			it_q <= in_beat;
			cur_q <= in_beat.target_reg;
			acc_q <= '0;
		end
		if (cmd.rd_base) begin
			base_q <= (stat.do_update || it_q.base_reg != 5'd0) ? rf_q[it_q.base_reg] : '0;
		end
		if (cmd.rd_index) begin
			off_q <= (it_q.indexed && !stat.is_multi) ? rf_q[it_q.index_reg] :
				32'(it_q.displacement);
		end
		if (cmd.calc_ea) begin
			ea_q <= base_q + off_q;
		end
		if (cmd.rd_src) begin
			rd_q <= rf_q[cur_q];
			acc_q <= '0;
		end
		if (cmd.mem_rd) begin
			acc_q <= {acc_q[23:0], rdata_q};
		end
		if (cmd.fin_elem) begin
			res <= '{reg_index: cur_q, data: it_q.command == ilsu_pkg::CMD_PRESET ?
				it_q.preset_value : v,
				address: it_q.command == ilsu_pkg::CMD_PRESET ? 32'd0 : ea_q,
				is_store: it_q.command == ilsu_pkg::CMD_STORE ||
					it_q.command == ilsu_pkg::CMD_STMW,
				last: !stat.is_multi || cur_q == 5'd31};
		end
		if (cmd.next_elem) begin
			cur_q <= cur_q + 5'd1;
			ea_q <= ea_q + 32'd4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ilsu_pkg::NUM_REGS; i++) rf_q[i] <= '0;
		end else if (cmd.wr_update) begin
			rf_q[it_q.base_reg] <= ea_q;
		end else if (cmd.fin_elem) begin
			if (it_q.command == ilsu_pkg::CMD_PRESET) begin
				rf_q[cur_q] <= it_q.preset_value;
			end else if (it_q.command == ilsu_pkg::CMD_LOAD ||
				it_q.command == ilsu_pkg::CMD_LMW) begin
				rf_q[cur_q] <= ldv;
			end
		end
	end
endmodule

// ----- hw/rtl/ilsu_ctrl.sv -----
// Controller state machine: sequences register reads, memory byte
// accesses and result beats. Depends on ilsu_pkg.
`timescale 1ns / 1ps
module ilsu_ctrl (
	input logic clk,
	input logic arst_n,
	input logic valid,
	output logic stall,
	output logic out_valid,
	input logic out_stall,
	input ilsu_pkg::ctl_stat_t stat,
	output ilsu_pkg::ctl_cmd_t cmd
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DEC = 4'd1;
	localparam logic [3:0] S_OPS = 4'd2;
	localparam logic [3:0] S_EA = 4'd3;
	localparam logic [3:0] S_SRC = 4'd4;
	localparam logic [3:0] S_MEM = 4'd5;
	localparam logic [3:0] S_RDW = 4'd6;
	localparam logic [3:0] S_FIN = 4'd7;
	localparam logic [3:0] S_OUT = 4'd8;
	localparam logic [3:0] S_UPD = 4'd9;

	logic [3:0] st_q, st_d;
	logic [1:0] k_q, k_d;
	logic ov_q, ov_d;
	logic is_ld;

	assign is_ld = stat.command == ilsu_pkg::CMD_LOAD || stat.command == ilsu_pkg::CMD_LMW;
	assign stall = st_q != S_IDLE;
	assign out_valid = ov_q;

	always_comb begin
		st_d = st_q;
		k_d = k_q;
		ov_d = ov_q && out_stall;
		cmd = '0;
		cmd.byte_k = k_q;
		case (st_q)
			S_IDLE: begin
				if (valid) begin
					cmd.latch_item = 1'b1;
					st_d = S_DEC;
				end
			end
			S_DEC: begin
				if (stat.command == ilsu_pkg::CMD_PRESET) st_d = S_FIN;
				else if (stat.command > ilsu_pkg::CMD_PRESET) st_d = S_IDLE;
				else begin
					cmd.rd_base = 1'b1;
					cmd.rd_index = 1'b1;
					st_d = S_OPS;
				end
			end
			S_OPS: begin
				cmd.calc_ea = 1'b1;
				st_d = S_EA;
			end
			S_EA, S_SRC: begin
				cmd.rd_src = 1'b1;
				k_d = 2'd0;
				st_d = S_MEM;
			end
			S_MEM: begin
				if (is_ld) begin
					st_d = S_RDW;
				end else begin
					cmd.mem_wr = 1'b1;
					if (3'(k_q) == stat.nbytes_m1) st_d = S_FIN;
					else k_d = k_q + 2'd1;
				end
			end
			S_RDW: begin
				cmd.mem_rd = 1'b1;
				if (3'(k_q) == stat.nbytes_m1) st_d = S_FIN;
				else begin
					k_d = k_q + 2'd1;
					st_d = S_MEM;
				end
			end
			S_FIN: begin
				if (!ov_q || !out_stall) begin
					cmd.fin_elem = 1'b1;
					ov_d = 1'b1;
					st_d = S_OUT;
				end
			end
			S_OUT: begin
				if (stat.is_multi && !stat.elem_last) begin
					cmd.next_elem = 1'b1;
					st_d = S_SRC;
				end else if (stat.do_update) begin
					st_d = S_UPD;
				end else begin
					st_d = S_IDLE;
				end
			end
			S_UPD: begin
				cmd.wr_update = 1'b1;
				st_d = S_IDLE;
			end
			default: st_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			k_q <= '0;
			ov_q <= 1'b0;
		end else begin
			st_q <= st_d;
			k_q <= k_d;
			ov_q <= ov_d;
		end
	end
endmodule

// ----- hw/rtl/integer_load_store_unit.sv -----
// Integer load/store unit. One item at a time: in_stall is high while the controller is
// not idle. How long an item takes is set by the byte memory port (one byte a cycle on
// stores; on loads each byte passes S_MEM then S_RDW); presets skip it, update adds S_UPD.
// Multiples give one result beat per register up to 31; a held out_stall adds to this.
// Reset clears the register file and control state; memory is not cleared.
// Depends on ilsu_pkg, ilsu_ctrl, ilsu_datapath.
`timescale 1ns / 1ps
module integer_load_store_unit #(
	parameter int unsigned MEM_BYTES = ilsu_pkg::MEM_BYTES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input ilsu_pkg::in_beat_t in_beat,
	output logic out_valid,
	input logic out_stall,
	output ilsu_pkg::out_beat_t out_beat
);
	ilsu_pkg::ctl_cmd_t cmd;
	ilsu_pkg::ctl_stat_t stat;

	ilsu_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .valid(in_valid), .stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .stat(stat), .cmd(cmd)
	);

	ilsu_datapath #(.MEM_BYTES(MEM_BYTES)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_beat(in_beat), .cmd(cmd),
		.stat(stat), .res(out_beat)
	);
endmodule

// ----- hw/rtl/ilsu_checker.sv -----
// Port-level checker for the integer load/store unit, bound to the top.
// Depends on ilsu_pkg.
`timescale 1ns / 1ps
module ilsu_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input ilsu_pkg::out_beat_t out_beat
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_beat))
		else $error("result beat changed while stalled");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("accepted beat while busy");
	a_preset_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_beat.is_store && out_beat.address == 32'd0 &&
		!out_beat.last |-> out_beat.reg_index != 5'd31)
		else $error("non-last result on last register");
	a_multi_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_beat.reg_index == 5'd31 |-> out_beat.last)
		else $error("register 31 result not last");
endmodule

bind integer_load_store_unit ilsu_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_beat(out_beat)
);

// ----- tb/ilsu_checker.sv -----
// Scoreboard for the integer load/store unit: watches both channels, predicts
// results from accepted input beats, compares output beats. Depends on ilsu_pkg.
`timescale 1ns / 1ps
module ilsu_scoreboard (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input ilsu_pkg::in_beat_t in_beat,
	input logic out_valid,
	input logic out_stall,
	input ilsu_pkg::out_beat_t out_beat,
	output int errors,
	output int pending
);
	logic [31:0] gpr [32];
	logic [7:0] mem [65536];
	ilsu_pkg::out_beat_t want_q [$];

	assign pending = want_q.size();

	function automatic logic [15:0] wrap(input logic [31:0] a, input int k);
		logic [31:0] s;
		s = a + k;
		return s[15:0];
	endfunction

	function automatic logic [31:0] swap_bytes(input logic [31:0] v, input int nb);
		if (nb == 2)
			return {16'h0, v[7:0], v[15:8]};
		return {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

	task automatic push(input logic [4:0] r, input logic [31:0] d, input logic [31:0] a,
			input logic st, input logic lst);
		ilsu_pkg::out_beat_t o;
		o.reg_index = r;
		o.data = d;
		o.address = a;
		o.is_store = st;
		o.last = lst;
		want_q = {want_q, o};
	endtask

	task automatic predict_access(input ilsu_pkg::in_beat_t b);
		logic [31:0] ea, v, disp;
		int nb;
		logic rev;
		disp = {{16{b.displacement[15]}}, b.displacement};
		if (b.command == ilsu_pkg::CMD_PRESET) begin
			gpr[b.target_reg] = b.preset_value;
			push(b.target_reg, b.preset_value, 32'h0, 1'b0, 1'b1);
		end else if (b.command == ilsu_pkg::CMD_LMW || b.command == ilsu_pkg::CMD_STMW) begin
			ea = (b.base_reg != 0 ? gpr[b.base_reg] : 32'h0) + disp;
			for (int r = b.target_reg; r <= 31; r++) begin
				if (b.command == ilsu_pkg::CMD_LMW) begin
					v = 0;
					for (int k = 0; k < 4; k++)
						v = {v[23:0], mem[wrap(ea, k)]};
					gpr[r] = v;
				end else begin
					v = gpr[r];
					for (int k = 0; k < 4; k++)
						mem[wrap(ea, k)] = v[8 * (3 - k) +: 8];
				end
				push(r[4:0], v, ea, b.command == ilsu_pkg::CMD_STMW, r == 31);
				ea += 4;
			end
		end else if (b.command == ilsu_pkg::CMD_LOAD || b.command == ilsu_pkg::CMD_STORE) begin
			nb = (b.access_size == ilsu_pkg::SZ_BYTE) ? 1 :
				(b.access_size == ilsu_pkg::SZ_HALF) ? 2 : 4;
			ea = ((b.update || b.base_reg != 0) ? gpr[b.base_reg] : 32'h0)
				+ (b.indexed ? gpr[b.index_reg] : disp);
			rev = b.byte_reverse && b.indexed && nb > 1;
			if (b.command == ilsu_pkg::CMD_LOAD) begin
				v = 0;
				for (int k = 0; k < nb; k++)
					v = {v[23:0], mem[wrap(ea, k)]};
				if (rev)
					v = swap_bytes(v, nb);
				else if (nb == 2 && b.sign_extend && v[15])
					v[31:16] = 16'hFFFF;
				gpr[b.target_reg] = v;
				push(b.target_reg, v, ea, 1'b0, 1'b1);
			end else begin
				v = gpr[b.target_reg];
				if (nb == 1)
					v &= 32'hFF;
				else if (nb == 2)
					v &= 32'hFFFF;
				if (rev)
					v = swap_bytes(v, nb);
				for (int k = 0; k < nb; k++)
					mem[wrap(ea, k)] = v[8 * (nb - 1 - k) +: 8];
				push(b.target_reg, v, ea, 1'b1, 1'b1);
			end
			if (b.update)
				gpr[b.base_reg] = ea;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		ilsu_pkg::out_beat_t w;
		if (!arst_n) begin
			for (int i = 0; i < 32; i++)
				gpr[i] = 0;
			want_q.delete();
			errors = 0;
		end else begin
			if (in_valid && !in_stall)
				predict_access(in_beat);
			if (out_valid && !out_stall) begin
				if (want_q.size() == 0) begin
					$error("unexpected beat reg_index=%0d", out_beat.reg_index);
					errors++;
				end else begin
					w = want_q.pop_front();
					if (w.reg_index !== out_beat.reg_index) begin
						$error("reg_index exp %0d got %0d", w.reg_index, out_beat.reg_index);
						errors++;
					end
					if (w.data !== out_beat.data) begin
						$error("data exp %h got %h", w.data, out_beat.data);
						errors++;
					end
					if (w.address !== out_beat.address) begin
						$error("address exp %h got %h", w.address, out_beat.address);
						errors++;
					end
					if (w.is_store !== out_beat.is_store) begin
						$error("is_store exp %b got %b", w.is_store, out_beat.is_store);
						errors++;
					end
					if (w.last !== out_beat.last) begin
						$error("last exp %b got %b", w.last, out_beat.last);
						errors++;
					end
				end
			end
		end
	end
endmodule

// ----- tb/tb_integer_load_store_unit.sv -----
// Testbench top for the integer load/store unit: directed and random access
// beats with random idling on both sides. Depends on ilsu_pkg, integer_load_store_unit, ilsu_scoreboard.
`timescale 1ns / 1ps
module tb_integer_load_store_unit;
	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	ilsu_pkg::in_beat_t in_beat = '0;
	logic out_valid;
	logic out_stall = 0;
	ilsu_pkg::out_beat_t out_beat;
	int errors, pending;
	int cycles = 0;
	bit written [65536];

	always #5 clk = ~clk;

	integer_load_store_unit dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_beat(in_beat), .out_valid(out_valid), .out_stall(out_stall),
		.out_beat(out_beat)
	);

	ilsu_scoreboard chk (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_beat(in_beat), .out_valid(out_valid), .out_stall(out_stall),
		.out_beat(out_beat), .errors(errors), .pending(pending)
	);

	// Shadow of register values so loads only touch written bytes.
	logic [31:0] regs [32];

	function automatic int gap_len();
		if ($urandom_range(0, 9) < 5)
			return 0;
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 2000000) begin
			$display("Mismatches found");
			$finish;
		end
	end

	int ostall_mode;
	int ostall_cnt = 0;
	always @(posedge clk) begin
		if (ostall_cnt > 0) begin
			ostall_cnt--;
			out_stall <= 1'b1;
		end else if (ostall_mode == 0)
			out_stall <= 1'b0;
		else if ($urandom_range(0, 99) < 2) begin
			ostall_cnt = $urandom_range(8, 40);
			out_stall <= 1'b1;
		end else
			out_stall <= ($urandom_range(0, 9) < 3);
	end

	function automatic bit ok_range(input logic [31:0] a, input int n);
		for (int k = 0; k < n; k++) begin
			logic [31:0] s;
			s = a + k;
			if (!written[s[15:0]])
				return 0;
		end
		return 1;
	endfunction

	function automatic void mark(input logic [31:0] a, input int n);
		for (int k = 0; k < n; k++) begin
			logic [31:0] s;
			s = a + k;
			written[s[15:0]] = 1;
		end
	endfunction

	// Mirrors the effect on shadow registers; returns 0 if beat would read unwritten memory.
	function automatic bit legal_apply(input ilsu_pkg::in_beat_t b);
		logic [31:0] ea, disp;
		int nb;
		disp = {{16{b.displacement[15]}}, b.displacement};
		if (b.command == ilsu_pkg::CMD_PRESET) begin
			regs[b.target_reg] = b.preset_value;
			return 1;
		end
		if (b.command > ilsu_pkg::CMD_PRESET)
			return 1;
		if (b.command == ilsu_pkg::CMD_LMW || b.command == ilsu_pkg::CMD_STMW) begin
			ea = (b.base_reg != 0 ? regs[b.base_reg] : 32'h0) + disp;
			if (b.command == ilsu_pkg::CMD_LMW) begin
				if (!ok_range(ea, 4 * (32 - b.target_reg)))
					return 0;
				for (int r = b.target_reg; r <= 31; r++)
					regs[r] = 32'hx;
			end else
				mark(ea, 4 * (32 - b.target_reg));
			return 1;
		end
		nb = (b.access_size == ilsu_pkg::SZ_BYTE) ? 1 :
			(b.access_size == ilsu_pkg::SZ_HALF) ? 2 : 4;
		ea = ((b.update || b.base_reg != 0) ? regs[b.base_reg] : 32'h0)
			+ (b.indexed ? regs[b.index_reg] : disp);
		if (b.command == ilsu_pkg::CMD_LOAD) begin
			if (!ok_range(ea, nb))
				return 0;
			regs[b.target_reg] = 32'hx;
		end else
			mark(ea, nb);
		if (b.update)
			regs[b.base_reg] = ea;
		return 1;
	endfunction

	task automatic send(input ilsu_pkg::in_beat_t b);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_beat <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	function automatic ilsu_pkg::in_beat_t mk(input logic [2:0] c, input logic [1:0] sz,
			input logic [4:0] rt, input logic [4:0] ra, input logic [15:0] d);
		ilsu_pkg::in_beat_t b;
		b = '0;
		b.command = c;
		b.access_size = sz;
		b.target_reg = rt;
		b.base_reg = ra;
		b.displacement = d;
		return b;
	endfunction

	function automatic ilsu_pkg::in_beat_t rand_beat();
		ilsu_pkg::in_beat_t b;
		b.command = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) :
			($urandom_range(0, 9) < 3) ? ilsu_pkg::CMD_PRESET : 3'($urandom_range(0, 3));
		b.access_size = 2'($urandom_range(0, 3));
		b.sign_extend = 1'($urandom);
		b.update = 1'($urandom);
		b.indexed = 1'($urandom);
		b.byte_reverse = 1'($urandom);
		b.target_reg = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) :
			5'($urandom_range(24, 31));
		b.base_reg = 5'($urandom);
		b.index_reg = 5'($urandom);
		b.displacement = 16'($urandom);
		b.preset_value = ($urandom_range(0, 1)) ? 32'($urandom) :
			32'($urandom_range(0, 255));
		return b;
	endfunction

	int sent;
	ilsu_pkg::in_beat_t b;
	int tries;
	initial begin
		ostall_mode = 0;
		for (int i = 0; i < 32; i++)
			regs[i] = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed
		b = mk(ilsu_pkg::CMD_PRESET, ilsu_pkg::SZ_BYTE, 5'd31, 5'd0, 16'h0);
		b.preset_value = 32'hFFFF_FFFF;
		void'(legal_apply(b)); send(b);
		b = mk(ilsu_pkg::CMD_PRESET, ilsu_pkg::SZ_BYTE, 5'd0, 5'd0, 16'h0);
		b.preset_value = 32'h8001_7F80;
		void'(legal_apply(b)); send(b);
		b = mk(ilsu_pkg::CMD_STORE, ilsu_pkg::SZ_WORD, 5'd31, 5'd0, 16'h7FFF);
		void'(legal_apply(b)); send(b);
		b = mk(ilsu_pkg::CMD_STORE, ilsu_pkg::SZ_HALF, 5'd0, 5'd0, 16'h8000);
		void'(legal_apply(b)); send(b);
		b = mk(ilsu_pkg::CMD_STORE, ilsu_pkg::SZ_BYTE, 5'd0, 5'd0, 16'h0010);
		void'(legal_apply(b)); send(b);
		b = mk(ilsu_pkg::CMD_LOAD, ilsu_pkg::SZ_HALF, 5'd3, 5'd0, 16'h8000);
		b.sign_extend = 1'b1;
		void'(legal_apply(b)); send(b);
		b = mk(ilsu_pkg::CMD_LOAD, ilsu_pkg::SZ_HALF, 5'd4, 5'd0, 16'h8000);
		void'(legal_apply(b)); send(b);
		b = mk(ilsu_pkg::CMD_LOAD, ilsu_pkg::SZ_BYTE, 5'd5, 5'd0, 16'h0010);
		void'(legal_apply(b)); send(b);
		b = mk(ilsu_pkg::CMD_LOAD, ilsu_pkg::SZ_WORD, 5'd6, 5'd0, 16'h7FFF);
		void'(legal_apply(b)); send(b);
		b = mk(ilsu_pkg::CMD_PRESET, ilsu_pkg::SZ_BYTE, 5'd7, 5'd0, 16'h0);
		b.preset_value = 32'h0000_7FFF;
		void'(legal_apply(b)); send(b);
		b = mk(ilsu_pkg::CMD_LOAD, ilsu_pkg::SZ_WORD, 5'd8, 5'd0, 16'h0);
		b.indexed = 1'b1; b.index_reg = 5'd7; b.byte_reverse = 1'b1;
		void'(legal_apply(b)); send(b);
		b = mk(ilsu_pkg::CMD_STORE, ilsu_pkg::SZ_HALF, 5'd31, 5'd0, 16'h0);
		b.indexed = 1'b1; b.index_reg = 5'd7; b.byte_reverse = 1'b1;
		void'(legal_apply(b)); send(b);
		b = mk(ilsu_pkg::CMD_LOAD, ilsu_pkg::SZ_HALF, 5'd9, 5'd0, 16'h0);
		b.indexed = 1'b1; b.index_reg = 5'd7; b.byte_reverse = 1'b1;
		b.sign_extend = 1'b1; void'(legal_apply(b)); send(b);
		b = mk(ilsu_pkg::CMD_STORE, ilsu_pkg::SZ_WORD, 5'd31, 5'd7, 16'hFFFC);
		b.update = 1'b1; void'(legal_apply(b)); send(b);
		b = mk(ilsu_pkg::CMD_LOAD, ilsu_pkg::SZ_WORD, 5'd7, 5'd7, 16'h0000);
		b.update = 1'b1; void'(legal_apply(b)); send(b);
		b = mk(ilsu_pkg::CMD_STORE, ilsu_pkg::SZ_BYTE, 5'd31, 5'd0, 16'h0100);
		b.update = 1'b1; void'(legal_apply(b)); send(b);
		b = mk(ilsu_pkg::CMD_PRESET, ilsu_pkg::SZ_BYTE, 5'd10, 5'd0, 16'h0);
		b.preset_value = 32'h0000_FFF0;
		void'(legal_apply(b)); send(b);
		b = mk(ilsu_pkg::CMD_STMW, ilsu_pkg::SZ_BYTE, 5'd0, 5'd10, 16'h0000);
		void'(legal_apply(b)); send(b);
		b = mk(ilsu_pkg::CMD_LMW, ilsu_pkg::SZ_BYTE, 5'd0, 5'd10, 16'h0000);
		b.update = 1'b1; b.indexed = 1'b1;
		void'(legal_apply(b)); send(b);
		b = mk(ilsu_pkg::CMD_STMW, ilsu_pkg::SZ_BYTE, 5'd31, 5'd0, 16'h0200);
		void'(legal_apply(b)); send(b);
		b = mk(ilsu_pkg::CMD_LMW, 2'd3, 5'd31, 5'd0, 16'h0200);
		void'(legal_apply(b)); send(b);
		b = mk(3'd6, ilsu_pkg::SZ_BYTE, 5'd1, 5'd1, 16'h0);
		void'(legal_apply(b)); send(b);
		ostall_mode = 1;
		sent = 0;
		while (sent < 210) begin
			tries = 0;
			do begin
				b = rand_beat();
				tries++;
			end while (!legal_apply(b) && tries < 50);
			if (tries >= 50) begin
				b = mk(ilsu_pkg::CMD_PRESET, ilsu_pkg::SZ_BYTE, 5'($urandom), 5'd0, 16'h0);
				b.preset_value = $urandom;
				void'(legal_apply(b));
			end
			if (sent % 50 == 25)
				ostall_mode = 0;
			else if (sent % 50 == 40)
				ostall_mode = 1;
			send(b);
			sent++;
		end
		in_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

// ----- filelist.f -----
hw/rtl/ilsu_pkg.sv
hw/rtl/ilsu_datapath.sv
hw/rtl/ilsu_ctrl.sv
hw/rtl/integer_load_store_unit.sv
hw/rtl/ilsu_checker.sv
tb/ilsu_checker.sv
tb/tb_integer_load_store_unit.sv
